// File: src/i2cmbe_pkg.sv
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the tick queue and the bus sequencer.
// ---------------------------------------------------------------------------
package i2cmbe_pkg;

   // Commands carried in the mode field. Codes five to seven are ignored.
   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_STOP    = 3'd1,
      CMD_WRITE   = 3'd2,
      CMD_READ    = 3'd3,
      CMD_RECOVER = 3'd4
   } cmd_type;

   // Sequencer phases. What each phase does depends on the active command.
   typedef enum logic [3:0] {
      PH_S0   = 4'd0,
      PH_S1   = 4'd1,
      PH_S2   = 4'd2,
      PH_S3   = 4'd3,
      PH_S4   = 4'd4,
      PH_S5   = 4'd5,
      PH_S6   = 4'd6,
      PH_IDLE = 4'd15
   } phase_type;

   // Number of SCL pulses given by a bus recovery.
   localparam logic [4:0] RECOVERY_PULSES = 5'd30;

   // Reset value of the phase length register.
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified tick as it waits in the queue.
   typedef struct packed {
      logic       cmd_go;
      cmd_type    mode;
      logic [7:0] wr_data;
      logic       send_nack;
      logic       sda_in;
   } tick_type;

endpackage

// File: src/i2cmbe_req_if.sv
// ---------------------------------------------------------------------------
// Tick request channel
// Valid/ready channel that carries one bus tick and its optional command.
// ---------------------------------------------------------------------------
interface i2cmbe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] mode;
   logic [7:0] wr_data;
   logic       send_nack;
   logic       sda_in;

   modport source (
      output valid, cmd_valid, mode, wr_data, send_nack, sda_in,
      input  ready
   );

   modport sink (
      input  valid, cmd_valid, mode, wr_data, send_nack, sda_in,
      output ready
   );
endinterface

// File: src/i2cmbe_rsp_if.sv
// ---------------------------------------------------------------------------
// Tick response channel
// Valid/ready channel that carries the bus levels and status after one tick.
// ---------------------------------------------------------------------------
interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rd_byte;
   logic       ack_seen;

   modport source (
      output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
             rd_byte, ack_seen,
      input  ready
   );

   modport sink (
      input  valid, scl_level, sda_level, sda_drive, busy_res, done_res,
             rd_byte, ack_seen,
      output ready
   );
endinterface

// File: src/i2c_master_byte_engine.sv
// ---------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, byte write, byte read, bus recovery.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one bus tick per transfer, with an optional command
//   (mode, wr_data, send_nack) and the sampled SDA level. rsp_bus returns one
//   transfer per tick with the SCL/SDA levels, SDA drive, busy, done, the last
//   read byte and the last write acknowledge.
//   csr_wr_en/csr_wr_data set the phase length in ticks (zero acts as one).
//   Write it only while no command is running.
// Pipeline and throughput:
//   A tick passes through the two-entry tick queue and then the sequencer's
//   result register before its response is offered.
//   One tick is taken every cycle while the queue has a free entry; the
//   sequencer updates its state once per tick.
// Reset:
//   Synchronous reset empties the queue, sets the sequencer idle with SCL and
//   SDA high and driven, and sets the phase length to 100 ticks.
// Stalls:
//   While rsp_bus is stalled the result holds and the queue fills; once it is
//   full req_bus.ready drops. No tick is lost or repeated.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine
   import i2cmbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   i2cmbe_req_if.sink       req_bus,
   i2cmbe_rsp_if.source     rsp_bus
);

   logic     q_valid;
   tick_type q_item;
   logic     q_pop;

   // Front end: accepts and classifies ticks.
   i2cmbe_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   // Back end: runs the bus sequencer.
   i2cmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp         (rsp_bus)
   );

endmodule

// File: src/i2cmbe_front.sv
// ---------------------------------------------------------------------------
// I2C master byte engine front end
// Accepts ticks, classifies the offered command and queues them for the back.
// ---------------------------------------------------------------------------
module i2cmbe_front
   import i2cmbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   i2cmbe_req_if.sink       req,
   output logic             q_valid,
   output tick_type         q_item,
   input  logic             q_pop
);

   tick_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push;
   logic                     pop;
   tick_type                 new_item;

   // The queue takes a transfer whenever it has a free entry.
   assign req.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   // A command only counts when it is offered and its code is known.
   always_comb begin
      new_item.cmd_go    = req.cmd_valid && (req.mode inside {[CMD_START:CMD_RECOVER]});
      new_item.mode      = cmd_type'(req.mode);
      new_item.wr_data   = req.wr_data;
      new_item.send_nack = req.send_nack;
      new_item.sda_in    = req.sda_in;
   end

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: src/i2cmbe_back.sv
// ---------------------------------------------------------------------------
// I2C master byte engine back end
// Runs the bus phase sequencer one queued tick at a time and holds the result.
// ---------------------------------------------------------------------------
module i2cmbe_back
   import i2cmbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   input  logic             q_valid,
   input  tick_type         q_item,
   output logic             q_pop,
   i2cmbe_rsp_if.source     rsp
);

   phase_type    phase_ff, phase_in;
   logic [15:0]  tick_ff, tick_in;
   logic [2:0]   bit_ff, bit_in;
   logic [7:0]   shift_ff, shift_in;
   cmd_type      cmd_ff, cmd_in;
   logic [4:0]   pulse_ff, pulse_in;
   logic [2:0]   lev_ff, lev_in;       // {scl, sda, drive}
   logic         ack_ff, ack_in;
   logic [7:0]   rd_ff, rd_in;
   logic         done_ff, done_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  ticks_cfg_ff, ticks_cfg_in;

   logic         pop;
   logic         idle;
   logic [15:0]  limit;
   logic         tick_end;
   logic [4:0]   pulse_inc;
   logic         go_enter;
   logic         go_finish;

   // Line levels set on entry to a phase; lines not named keep their level.
   function automatic logic [2:0] line_levels(
      input cmd_type   cmd,
      input phase_type ph,
      input logic [7:0] shift,
      input logic [2:0] bit_idx,
      input logic       nack,
      input logic [2:0] cur
   );
      logic scl;
      logic sda;
      logic drv;
      scl = cur[2];
      sda = cur[1];
      drv = cur[0];
      case (cmd)
         CMD_START: begin
            case (ph)
               PH_S0:   drv = 1'b1;
               PH_S1:   sda = 1'b1;
               PH_S2:   scl = 1'b1;
               PH_S3:   sda = 1'b0;
               default: scl = 1'b0;
            endcase
         end
         CMD_STOP: begin
            case (ph)
               PH_S0: scl = 1'b0;
               PH_S1: begin
                  drv = 1'b1;
                  sda = 1'b0;
               end
               PH_S2:   scl = 1'b1;
               default: sda = 1'b1;
            endcase
         end
         CMD_WRITE, CMD_READ: begin
            case (ph)
               PH_S0, PH_S3, PH_S6: scl = 1'b0;
               PH_S2, PH_S5:        scl = 1'b1;
               PH_S1: begin
                  if (cmd == CMD_WRITE) begin
                     drv = 1'b1;
                     sda = shift[bit_idx];
                  end else begin
                     drv = 1'b0;
                  end
               end
               default: begin
                  // Acknowledge slot: released on a write, driven on a read.
                  if (cmd == CMD_WRITE) begin
                     drv = 1'b0;
                  end else begin
                     drv = 1'b1;
                     sda = nack;
                  end
               end
            endcase
         end
         default: begin
            case (ph)
               PH_S0: begin
                  drv = 1'b1;
                  scl = 1'b1;
                  sda = 1'b1;
               end
               PH_S1:   scl = 1'b0;
               default: scl = 1'b1;
            endcase
         end
      endcase
      return {scl, sda, drv};
   endfunction

   // A queued tick is taken when the result register is free or being drained.
   assign pop       = q_valid && (!rsp_valid_ff || rsp.ready);
   assign q_pop     = pop;
   assign idle      = (phase_ff == PH_IDLE);
   assign limit     = (ticks_cfg_ff == '0) ? 16'd1 : ticks_cfg_ff;
   assign tick_end  = (tick_ff >= limit);
   assign pulse_inc = pulse_ff + 5'd1;

   // Phase sequencing: next phase, and whether a phase is entered or the
   // command finishes on this tick.
   always_comb begin
      phase_in  = phase_ff;
      go_enter  = 1'b0;
      go_finish = 1'b0;
      if (pop) begin
         if (idle) begin
            if (q_item.cmd_go) begin
               phase_in = PH_S0;
               go_enter = 1'b1;
            end
         end else if (tick_end) begin
            case (cmd_ff)
               CMD_START: begin
                  if (phase_ff inside {[PH_S0:PH_S3]}) begin
                     phase_in = phase_type'(phase_ff + 4'd1);
                     go_enter = 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     go_finish = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (phase_ff inside {[PH_S0:PH_S2]}) begin
                     phase_in = phase_type'(phase_ff + 4'd1);
                     go_enter = 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     go_finish = 1'b1;
                  end
               end
               CMD_WRITE, CMD_READ: begin
                  case (phase_ff)
                     PH_S2: begin
                        phase_in = (bit_ff != '0) ? PH_S0 : PH_S3;
                        go_enter = 1'b1;
                     end
                     PH_S5: begin
                        phase_in = PH_S6;
                        go_enter = 1'b1;
                     end
                     PH_S6: begin
                        phase_in  = PH_IDLE;
                        go_finish = 1'b1;
                     end
                     default: begin
                        phase_in = phase_type'(phase_ff + 4'd1);
                        go_enter = 1'b1;
                     end
                  endcase
               end
               default: begin
                  if (phase_ff inside {PH_S0, PH_S1}) begin
                     phase_in = phase_type'(phase_ff + 4'd1);
                     go_enter = 1'b1;
                  end else if (pulse_inc < RECOVERY_PULSES) begin
                     phase_in = PH_S1;
                     go_enter = 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     go_finish = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Datapath: counters, shift register, samples and line levels.
   always_comb begin
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      cmd_in    = cmd_ff;
      pulse_in  = pulse_ff;
      lev_in    = lev_ff;
      ack_in    = ack_ff;
      rd_in     = rd_ff;
      done_in   = done_ff;
      if (pop) begin
         done_in = go_finish;
         if (idle) begin
            if (q_item.cmd_go) begin
               cmd_in   = q_item.mode;
               bit_in   = 3'd7;
               shift_in = (q_item.mode == CMD_WRITE) ? q_item.wr_data : 8'd0;
               pulse_in = (q_item.mode == CMD_READ) ? {4'd0, q_item.send_nack} : 5'd0;
            end
         end else if (tick_end) begin
            case (cmd_ff)
               CMD_WRITE, CMD_READ: begin
                  // Samples are taken at the end of the SCL high phases.
                  if (phase_ff == PH_S2) begin
                     if (cmd_ff == CMD_READ) begin
                        shift_in = {shift_ff[6:0], q_item.sda_in};
                     end
                     if (bit_ff != '0) begin
                        bit_in = bit_ff - 3'd1;
                     end
                  end
                  if (phase_ff == PH_S5 && cmd_ff == CMD_WRITE) begin
                     ack_in = q_item.sda_in;
                  end
                  if (phase_ff == PH_S6 && cmd_ff == CMD_READ) begin
                     rd_in = shift_ff;
                  end
               end
               CMD_RECOVER: begin
                  if (!(phase_ff inside {PH_S0, PH_S1})) begin
                     pulse_in = pulse_inc;
                  end
               end
               default: begin
               end
            endcase
         end
         if (go_enter) begin
            tick_in = 16'd1;
            lev_in  = line_levels(cmd_in, phase_in, shift_in, bit_in, pulse_in[0], lev_ff);
         end else if (go_finish) begin
            tick_in = 16'd0;
         end else if (!idle) begin
            tick_in = tick_ff + 16'd1;
         end
      end
   end

   // Result register handshake and configuration register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      ticks_cfg_in = csr_wr_en ? csr_wr_data : ticks_cfg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         cmd_ff       <= CMD_START;
         pulse_ff     <= '0;
         lev_ff       <= 3'b111;
         ack_ff       <= 1'b0;
         rd_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_cfg_ff <= PHASE_TICKS_RESET;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         cmd_ff       <= cmd_in;
         pulse_ff     <= pulse_in;
         lev_ff       <= lev_in;
         ack_ff       <= ack_in;
         rd_ff        <= rd_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         ticks_cfg_ff <= ticks_cfg_in;
      end
   end

   // State only moves when a tick is taken, so it doubles as the result.
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.scl_level = lev_ff[2];
   assign rsp.sda_level = lev_ff[1];
   assign rsp.sda_drive = lev_ff[0];
   assign rsp.busy_res  = !idle;
   assign rsp.done_res  = done_ff;
   assign rsp.rd_byte   = rd_ff;
   assign rsp.ack_seen  = ack_ff;

endmodule

// File: src/i2cmbe_checker.sv
// ---------------------------------------------------------------------------
// I2C master byte engine checker
// Port-level assertions on the response stream, bound to the top level.
// ---------------------------------------------------------------------------
module i2cmbe_checker
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       scl_level,
   input  logic       sda_level,
   input  logic       sda_drive,
   input  logic       busy_res,
   input  logic       done_res,
   input  logic [7:0] rd_byte,
   input  logic       ack_seen
);

   logic rsp_xfer;
   logic last_busy_ff;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // Busy flag of the last response transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_busy_ff <= 1'b0;
      end else if (rsp_xfer) begin
         last_busy_ff <= busy_res;
      end
   end

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({scl_level, sda_level, sda_drive, busy_res, done_res, rd_byte, ack_seen}))
      else $error("stalled response changed");

   // A command only stops being busy by completing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && last_busy_ff && !busy_res |-> done_res)
      else $error("busy dropped without done");

   // Completion follows a busy tick and leaves the engine idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && done_res |-> last_busy_ff && !busy_res)
      else $error("done without a running command");

   // An empty response stage fills only from an accepted tick, held first in
   // the queue and then loaded into the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a tick");

endmodule

bind i2c_master_byte_engine i2cmbe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .scl_level (rsp_bus.scl_level),
   .sda_level (rsp_bus.sda_level),
   .sda_drive (rsp_bus.sda_drive),
   .busy_res  (rsp_bus.busy_res),
   .done_res  (rsp_bus.done_res),
   .rd_byte   (rsp_bus.rd_byte),
   .ack_seen  (rsp_bus.ack_seen)
);
